// ===== sv/pgl_pkg.sv =====
// shared types and constants for the palette gradient lerp block
`timescale 1ns / 1ps
`default_nettype none
package pgl_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int FRAC_BITS     = 16;
	localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
	localparam int LEN_W         = ADDR_W + 1;
	localparam int POS_W         = FRAC_BITS + 1;
	localparam int CH_W          = 8;
	localparam int COLOR_W       = 3 * CH_W;
	localparam int PROD_W        = POS_W + LEN_W;
	localparam int BLEND_W       = CH_W + POS_W;

	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(PALETTE_DEPTH);
	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(1);
	localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1) << FRAC_BITS;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_PICK  = 2'd1;
	localparam logic [1:0] CMD_LERP  = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [7:0]       entry_index;
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
		logic [POS_W-1:0] position;
	} pgl_req_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            result_valid;
	} pgl_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ2 = 3'b010,
		ST_BLEND = 3'b100
	} pgl_state_t;

endpackage
`default_nettype wire

// ===== sv/pgl_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pgl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/palette_gradient_lerp_top.sv =====
// top level of the palette gradient lerp block
//
// channel | direction | handshake         | beat
// --------+-----------+-------------------+-----------------------------------
// req     | in        | req_valid/stall   | pgl_req_t: write, pick or lerp cmd
// rsp     | out       | rsp_valid/stall   | pgl_rsp_t: color plus valid flag
// cfg     | in        | cfg_valid/ready   | 9-bit palette length
//
// a pick or lerp beat reads the single-port palette ram twice (entry i, then
// entry i+1)
// reset clears the state machine, the output valid flag and sets length 256;
// palette contents are undefined until written
// a stalled result sits in the output register while the next beat is taken;
// input is held off during the second read and when a finished blend has
// nowhere to go
`timescale 1ns / 1ps
`default_nettype none
module palette_gradient_lerp_top
	import pgl_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire pgl_req_t        req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output pgl_rsp_t             rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [LEN_W-1:0] cfg_data
);

	// control state
	pgl_state_t       state_q;
	logic [LEN_W-1:0] len_q;
	logic             out_full_q;
	pgl_rsp_t         rsp_q;

	// per-item payload carried across the two reads
	logic [ADDR_W-1:0]    idx_s1;
	logic [FRAC_BITS-1:0] frac_s1;
	logic                 bad_s1;
	logic                 next_ok_s1;
	logic [COLOR_W-1:0]   c1_s2;

	// handshake
	logic accept;
	logic out_free;
	logic is_write;
	logic is_pick;
	logic is_lerp;
	logic start;

	// address math on the incoming beat
	logic [LEN_W-1:0]     mul_op;
	logic [PROD_W-1:0]    prod;
	logic [ADDR_W-1:0]    idx_w;
	logic [FRAC_BITS-1:0] frac_w;
	logic                 bad_w;
	logic                 next_ok_w;
	logic                 write_ok;

	// ram port
	logic               ram_en;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [COLOR_W-1:0] ram_wdata;
	logic [COLOR_W-1:0] ram_rdata;

	// blend
	logic [COLOR_W-1:0] c2;
	logic [POS_W-1:0]   w1;
	logic [POS_W-1:0]   w2;
	logic [CH_W-1:0]    blend_ch [3];
	pgl_rsp_t           rsp_d;

	assign out_free  = !out_full_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) || ((state_q == ST_BLEND) && out_free));
	assign accept    = req_valid && !req_stall;
	assign is_write  = (req.cmd == CMD_WRITE);
	assign is_pick   = (req.cmd == CMD_PICK);
	assign is_lerp   = (req.cmd == CMD_LERP);
	assign start     = accept && (is_pick || is_lerp);
	assign cfg_ready = 1'b1;

	// pick scales by length, lerp by length minus one
	assign mul_op = is_lerp ? (len_q - LEN_MIN) : len_q;
	assign prod   = PROD_W'(req.position) * PROD_W'(mul_op);
	assign idx_w  = prod[FRAC_BITS +: ADDR_W];
	assign frac_w = is_lerp ? prod[FRAC_BITS-1:0] : '0;
	// pick wants position below 1.0, lerp allows exactly 1.0
	assign bad_w  = is_lerp ? (req.position > ONE_POS) : (req.position >= ONE_POS);
	// the entry after the last one in use reads as black; pick never uses it
	assign next_ok_w = is_lerp && ((LEN_W'(idx_w) + LEN_MIN) < len_q);
	assign write_ok  = LEN_W'(req.entry_index) < len_q;

	assign ram_we    = accept && is_write && write_ok;
	assign ram_en    = ram_we || start || (state_q == ST_READ2);
	assign ram_wdata = {req.red_in, req.green_in, req.blue_in};
	always_comb begin
		if (state_q == ST_READ2) begin
			ram_addr = idx_s1 + ADDR_W'(1);
		end else if (is_write) begin
			ram_addr = req.entry_index;
		end else begin
			ram_addr = idx_w;
		end
	end

	pgl_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// blend each channel: floor((c1*(1-f) + c2*f) / 1.0)
	assign c2 = next_ok_s1 ? ram_rdata : '0;
	assign w2 = POS_W'(frac_s1);
	assign w1 = ONE_POS - w2;

	always_comb begin
		logic [BLEND_W-1:0] total;
		total = '0;
		for (int ch = 0; ch < 3; ch++) begin
			total = BLEND_W'(c1_s2[ch*CH_W +: CH_W]) * BLEND_W'(w1)
				+ BLEND_W'(c2[ch*CH_W +: CH_W]) * BLEND_W'(w2);
			blend_ch[ch] = total[FRAC_BITS +: CH_W];
		end
	end

	always_comb begin
		if (bad_s1) begin
			rsp_d = '0;
		end else begin
			rsp_d.red_out      = blend_ch[2];
			rsp_d.green_out    = blend_ch[1];
			rsp_d.blue_out     = blend_ch[0];
			rsp_d.result_valid = 1'b1;
		end
	end

	// sequencer: accept -> second read -> blend into output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_READ2;
					end
				end
				ST_READ2: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					if (out_free) begin
						state_q <= start ? ST_READ2 : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			idx_s1     <= idx_w;
			frac_s1    <= frac_w;
			bad_s1     <= bad_w;
			next_ok_s1 <= next_ok_w;
		end
		if (state_q == ST_READ2) begin
			c1_s2 <= ram_rdata;
		end
		if ((state_q == ST_BLEND) && out_free) begin
			rsp_q <= rsp_d;
		end
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if ((state_q == ST_BLEND) && out_free) begin
			out_full_q <= 1'b1;
		end else if (out_full_q && !rsp_stall) begin
			out_full_q <= 1'b0;
		end
	end

	// palette length, clamped to 1..depth on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data < LEN_MIN) begin
				len_q <= LEN_MIN;
			end else if (cfg_data > LEN_MAX) begin
				len_q <= LEN_MAX;
			end else begin
				len_q <= cfg_data;
			end
		end
	end

	assign rsp_valid = out_full_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_read2_to_blend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ2 |=> state_q == ST_BLEND)
		else $error("second read not followed by blend");

	a_blend_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) && !out_full_q |=> out_full_q)
		else $error("blend with free output did not load a result");

	a_write_only_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> accept && (req.cmd == CMD_WRITE) && (state_q != ST_READ2))
		else $error("palette write without an accepted write beat");
`endif

endmodule
`default_nettype wire
